// ----- hdl/tcch_pkg.sv -----
// Shared types, constants and CORDIC helpers for the tilt-compensated compass heading.
package tcch_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  localparam int VW = 56;  // vectoring x/y width
  localparam int AW = 34;  // angle and Q30 width

  localparam logic signed [AW-1:0] ANG_PI      = 34'sh0_8000_0000;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sh0_4000_0000;
  localparam logic signed [AW-1:0] GAIN_Q30    = 34'sh0_26DD_3B6A;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] a;
    logic                 neg;
  } rot_t;

  typedef struct packed {
    logic signed [15:0]   mx;
    logic signed [15:0]   my;
    logic signed [15:0]   mz;
    logic signed [15:0]   gx;
    logic signed [15:0]   gy;
    logic signed [15:0]   gz;
    logic signed [AW-1:0] sp;
    logic signed [AW-1:0] cp;
  } side_t;

  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AW-1:0] r;
    unique case (i)
      5'd0:  r = 34'sh20000000;
      5'd1:  r = 34'sh12E4051D;
      5'd2:  r = 34'sh09FB385B;
      5'd3:  r = 34'sh051111D4;
      5'd4:  r = 34'sh028B0D43;
      5'd5:  r = 34'sh0145D7E1;
      5'd6:  r = 34'sh00A2F61E;
      5'd7:  r = 34'sh00517C55;
      5'd8:  r = 34'sh0028BE53;
      5'd9:  r = 34'sh00145F2E;
      5'd10: r = 34'sh000A2F98;
      5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6;
      5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2F9;
      5'd15: r = 34'sh0000517C;
      5'd16: r = 34'sh000028BE;
      5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A2F;
      5'd19: r = 34'sh00000517;
      5'd20: r = 34'sh0000028B;
      5'd21: r = 34'sh00000145;
      5'd22: r = 34'sh000000A2;
      5'd23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // quadrant pre-rotation ahead of the vectoring chain
  function automatic vec_t pre_vec(input logic signed [VW-1:0] y,
                                   input logic signed [VW-1:0] x);
    vec_t v;
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y;
        v.y = -x;
        v.z = ANG_HALF_PI;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -ANG_HALF_PI;
      end
    end
    return v;
  endfunction

  // fold into +/-pi/2 ahead of the rotation chain
  function automatic rot_t rot_init(input logic signed [AW-1:0] a);
    rot_t r;
    r.x   = GAIN_Q30;
    r.y   = '0;
    r.a   = a;
    r.neg = 1'b0;
    if (a > ANG_HALF_PI) begin
      r.a   = a - ANG_PI;
      r.neg = 1'b1;
    end else if (a < -ANG_HALF_PI) begin
      r.a   = a + ANG_PI;
      r.neg = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/tcch_vec_cell.sv -----
// One vectoring CORDIC micro-rotation cell.
module tcch_vec_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [4:0]       idx,
  input  logic             vld_i,
  input  tcch_pkg::vec_t   d_i,
  input  tcch_pkg::side_t  side_i,
  output logic             vld_o,
  output tcch_pkg::vec_t   d_o,
  output tcch_pkg::side_t  side_o
);

  logic           vld_r;
  tcch_pkg::vec_t d_r, d_nxt;
  tcch_pkg::side_t side_r;

  always_comb begin
    d_nxt = d_i;
    if (d_i.y >= 0) begin
      d_nxt.x = d_i.x + (d_i.y >>> idx);
      d_nxt.y = d_i.y - (d_i.x >>> idx);
      d_nxt.z = d_i.z + tcch_pkg::atan_tab(idx);
    end else begin
      d_nxt.x = d_i.x - (d_i.y >>> idx);
      d_nxt.y = d_i.y + (d_i.x >>> idx);
      d_nxt.z = d_i.z - tcch_pkg::atan_tab(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

// ----- hdl/tcch_rot_cell.sv -----
// One rotation CORDIC micro-rotation cell (sine/cosine).
module tcch_rot_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [4:0]       idx,
  input  logic             vld_i,
  input  tcch_pkg::rot_t   d_i,
  input  tcch_pkg::side_t  side_i,
  output logic             vld_o,
  output tcch_pkg::rot_t   d_o,
  output tcch_pkg::side_t  side_o
);

  logic           vld_r;
  tcch_pkg::rot_t d_r, d_nxt;
  tcch_pkg::side_t side_r;

  always_comb begin
    d_nxt = d_i;
    if (d_i.a >= 0) begin
      d_nxt.x = d_i.x - (d_i.y >>> idx);
      d_nxt.y = d_i.y + (d_i.x >>> idx);
      d_nxt.a = d_i.a - tcch_pkg::atan_tab(idx);
    end else begin
      d_nxt.x = d_i.x + (d_i.y >>> idx);
      d_nxt.y = d_i.y - (d_i.x >>> idx);
      d_nxt.a = d_i.a + tcch_pkg::atan_tab(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

// ----- hdl/tilt_compensated_compass_heading.sv -----
// Tilt-compensated compass heading: five CORDIC cell chains with glue stages.
// Throughput: one request per cycle while the output is not stalled; each CORDIC stage is its own cell register.
// The whole pipeline holds while a result waits at the output register.
// Reset (synchronous, active low) clears all valid bits and sets declination to 0.
module tilt_compensated_compass_heading (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // mag_x, mag_y, mag_z, grav_x, grav_y, grav_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // heading[16:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // declination
);

  localparam int N  = tcch_pkg::NSTG;
  localparam int VW = tcch_pkg::VW;
  localparam int AW = tcch_pkg::AW;

  logic en;
  logic signed [15:0] decl_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= '0;
    end else if (cfg_valid) begin
      decl_r <= cfg_data;
    end
  end

  // valid bits of the glue stages
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;

  // chain buses
  tcch_pkg::vec_t  a_d [N+1];
  tcch_pkg::side_t a_s [N+1];
  logic            a_v [N+1];
  tcch_pkg::rot_t  b_d [N+1];
  tcch_pkg::side_t b_s [N+1];
  logic            b_v [N+1];
  tcch_pkg::vec_t  c_d [N+1];
  tcch_pkg::side_t c_s [N+1];
  logic            c_v [N+1];
  tcch_pkg::rot_t  d_d [N+1];
  tcch_pkg::side_t d_s [N+1];
  logic            d_v [N+1];
  tcch_pkg::vec_t  e_d [N+1];
  tcch_pkg::side_t e_s [N+1];
  logic            e_v [N+1];

  // S0: input register with pre-rotation for roll
  tcch_pkg::side_t s0_side_nxt;
  always_comb begin
    s0_side_nxt.mx = in_tdata[15:0];
    s0_side_nxt.my = in_tdata[31:16];
    s0_side_nxt.mz = in_tdata[47:32];
    s0_side_nxt.gx = in_tdata[63:48];
    s0_side_nxt.gy = in_tdata[79:64];
    s0_side_nxt.gz = in_tdata[95:80];
    s0_side_nxt.sp = '0;
    s0_side_nxt.cp = '0;
  end

  tcch_pkg::vec_t  s0_d_r;
  tcch_pkg::side_t s0_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r <= tcch_pkg::pre_vec(VW'(s0_side_nxt.gy), VW'(s0_side_nxt.gz));
      s0_s_r <= s0_side_nxt;
    end
  end
  assign a_d[0] = s0_d_r;
  assign a_s[0] = s0_s_r;
  assign a_v[0] = v0_r;

  // S1: roll angle into sin/cos chain
  logic signed [AW-1:0] phi;
  assign phi = a_d[N].zero ? '0 : a_d[N].z;
  tcch_pkg::rot_t  s1_d_r;
  tcch_pkg::side_t s1_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r <= tcch_pkg::rot_init(phi);
      s1_s_r <= a_s[N];
    end
  end
  assign b_d[0] = s1_d_r;
  assign b_s[0] = s1_s_r;
  assign b_v[0] = v1_r;

  // S2: pitch argument products
  logic signed [AW-1:0] sp, cp;
  assign sp = b_d[N].neg ? -b_d[N].y : b_d[N].y;
  assign cp = b_d[N].neg ? -b_d[N].x : b_d[N].x;
  tcch_pkg::side_t s2_side_nxt;
  always_comb begin
    s2_side_nxt    = b_s[N];
    s2_side_nxt.sp = sp;
    s2_side_nxt.cp = cp;
  end
  logic signed [VW-1:0] p_gs_r, p_gc_r, p_ny_r;
  tcch_pkg::side_t s2_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_gs_r <= VW'(b_s[N].gy) * VW'(sp);
      p_gc_r <= VW'(b_s[N].gz) * VW'(cp);
      p_ny_r <= -(VW'(b_s[N].gx) <<< 30);
      s2_s_r <= s2_side_nxt;
    end
  end

  // S3: pitch vector into vectoring chain
  tcch_pkg::vec_t  s3_d_r;
  tcch_pkg::side_t s3_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_d_r <= tcch_pkg::pre_vec(p_ny_r, p_gs_r + p_gc_r);
      s3_s_r <= s2_s_r;
    end
  end
  assign c_d[0] = s3_d_r;
  assign c_s[0] = s3_s_r;
  assign c_v[0] = v3_r;

  // S4: fold pitch into +/-pi/2
  logic signed [AW-1:0] th0, th;
  always_comb begin
    th0 = c_d[N].zero ? '0 : c_d[N].z;
    th  = th0;
    if (th0 > tcch_pkg::ANG_HALF_PI) begin
      th = tcch_pkg::ANG_PI - th0;
    end else if (th0 < -tcch_pkg::ANG_HALF_PI) begin
      th = -tcch_pkg::ANG_PI - th0;
    end
  end
  tcch_pkg::rot_t  s4_d_r;
  tcch_pkg::side_t s4_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_d_r <= tcch_pkg::rot_init(th);
      s4_s_r <= c_s[N];
    end
  end
  assign d_d[0] = s4_d_r;
  assign d_s[0] = s4_s_r;
  assign d_v[0] = v4_r;

  // S5: tilt products
  logic signed [AW-1:0] st, ct0, ct;
  assign st  = d_d[N].neg ? -d_d[N].y : d_d[N].y;
  assign ct0 = d_d[N].neg ? -d_d[N].x : d_d[N].x;
  assign ct  = (ct0 < 0) ? -ct0 : ct0;
  logic signed [2*AW-1:0] q_ss_r, q_sc_r;
  logic signed [VW-1:0]   m_xc_r, n_zs_r, n_yc_r;
  tcch_pkg::side_t s5_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q_ss_r <= (2*AW)'(st) * (2*AW)'(d_s[N].sp);
      q_sc_r <= (2*AW)'(st) * (2*AW)'(d_s[N].cp);
      m_xc_r <= VW'(d_s[N].mx) * VW'(ct);
      n_zs_r <= VW'(d_s[N].mz) * VW'(d_s[N].sp);
      n_yc_r <= VW'(d_s[N].my) * VW'(d_s[N].cp);
      s5_s_r <= d_s[N];
    end
  end

  // S6: Q60 back to Q30, second products, numerator
  logic signed [2*AW-1:0] ss_sh, sc_sh;
  assign ss_sh = q_ss_r >>> 30;
  assign sc_sh = q_sc_r >>> 30;
  logic signed [VW-1:0] t_y_r, t_z_r, m_xc6_r, num_r;
  tcch_pkg::side_t s6_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      t_y_r   <= VW'(s5_s_r.my) * VW'($signed(ss_sh[AW-1:0]));
      t_z_r   <= VW'(s5_s_r.mz) * VW'($signed(sc_sh[AW-1:0]));
      m_xc6_r <= m_xc_r;
      num_r   <= n_zs_r - n_yc_r;
      s6_s_r  <= s5_s_r;
    end
  end

  // S7: denominator, heading vector into vectoring chain
  tcch_pkg::vec_t  s7_d_r;
  tcch_pkg::side_t s7_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_d_r <= tcch_pkg::pre_vec(num_r, m_xc6_r + t_y_r + t_z_r);
      s7_s_r <= s6_s_r;
    end
  end
  assign e_d[0] = s7_d_r;
  assign e_s[0] = s7_s_r;
  assign e_v[0] = v7_r;

  // S8: binary angle to hundredths of a degree, minus declination
  logic signed [AW-1:0] h;
  logic signed [49:0]   hs, hq;
  logic signed [16:0]   head_nxt;
  logic [16:0]          head_r;
  assign h        = e_d[N].zero ? '0 : e_d[N].z;
  assign hs       = 50'(h) * 50'sd18000 + 50'sd1073741824;
  assign hq       = hs >>> 31;
  assign head_nxt = hq[16:0] - 17'(decl_r);
  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= a_v[N];
      v2_r <= b_v[N];
      v3_r <= v2_r;
      v4_r <= c_v[N];
      v5_r <= d_v[N];
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= e_v[N];
    end
  end

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cells
      tcch_vec_cell u_a (
        .clk(clk), .rst_n(rst_n), .en(en), .idx(5'(k)),
        .vld_i(a_v[k]), .d_i(a_d[k]), .side_i(a_s[k]),
        .vld_o(a_v[k+1]), .d_o(a_d[k+1]), .side_o(a_s[k+1]));
      tcch_rot_cell u_b (
        .clk(clk), .rst_n(rst_n), .en(en), .idx(5'(k)),
        .vld_i(b_v[k]), .d_i(b_d[k]), .side_i(b_s[k]),
        .vld_o(b_v[k+1]), .d_o(b_d[k+1]), .side_o(b_s[k+1]));
      tcch_vec_cell u_c (
        .clk(clk), .rst_n(rst_n), .en(en), .idx(5'(k)),
        .vld_i(c_v[k]), .d_i(c_d[k]), .side_i(c_s[k]),
        .vld_o(c_v[k+1]), .d_o(c_d[k+1]), .side_o(c_s[k+1]));
      tcch_rot_cell u_d (
        .clk(clk), .rst_n(rst_n), .en(en), .idx(5'(k)),
        .vld_i(d_v[k]), .d_i(d_d[k]), .side_i(d_s[k]),
        .vld_o(d_v[k+1]), .d_o(d_d[k+1]), .side_o(d_s[k+1]));
      tcch_vec_cell u_e (
        .clk(clk), .rst_n(rst_n), .en(en), .idx(5'(k)),
        .vld_i(e_v[k]), .d_i(e_d[k]), .side_i(e_s[k]),
        .vld_o(e_v[k+1]), .d_o(e_d[k+1]), .side_o(e_s[k+1]));
    end
  endgenerate

  assign out_tvalid = v8_r;
  assign out_tdata  = {7'd0, head_r};

endmodule

// ----- hdl/tcch_checker.sv -----
// Port-level checker for the compass heading block, bound to the top level.
module tcch_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0)
    else $error("result pad bits not zero");

endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- tb/tb_top.sv -----
// Testbench for the tilt-compensated compass heading pipeline.
`timescale 1ns / 100ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // mag_x, mag_y, mag_z, grav_x, grav_y, grav_z
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // heading[16:0], zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;   // declination

  tilt_compensated_compass_heading u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  localparam longint HALF_PI_A = 64'sd1073741824;
  localparam longint PI_A      = 64'sd2147483648;
  localparam longint GAIN      = 64'sh26DD3B6A;
  localparam int     WATCHDOG  = 3000;

  longint arctan_lut[24] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  logic [95:0]        sample_q[$];
  logic signed [16:0] heading_q[$];
  logic signed [15:0] decl_copy = '0;
  int  cfg_writes = 0;
  int  n_sent = 0, n_checked = 0, n_errors = 0;
  bit  calm = 1'b0;
  bit  in_acc = 1'b0, out_acc = 1'b0;
  int  send_gap = 0, recv_stall = 0, idle_cycles = 0;

  function automatic longint vec_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_A;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_A;
      end
    end
    for (int i = 0; i < tcch_pkg::NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_lut[i];
      end else begin
        x -= dx; y += dy; z -= arctan_lut[i];
      end
    end
    return z;
  endfunction

  task automatic sin_cos(input longint a, output longint s, output longint c);
    longint x, y, dx, dy;
    bit flip;
    x = GAIN; y = 0; flip = 1'b0;
    if (a > HALF_PI_A) begin
      a -= PI_A; flip = 1'b1;
    end else if (a < -HALF_PI_A) begin
      a += PI_A; flip = 1'b1;
    end
    for (int i = 0; i < tcch_pkg::NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= arctan_lut[i];
      end else begin
        x += dx; y -= dy; a += arctan_lut[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic compass_heading(input logic [95:0] d, output logic signed [16:0] hd);
    longint mx, my, mz, gx, gy, gz, roll, pitch, sr, cr, sp, cp, num, den, h, deg;
    mx = $signed(d[15:0]);  my = $signed(d[31:16]); mz = $signed(d[47:32]);
    gx = $signed(d[63:48]); gy = $signed(d[79:64]); gz = $signed(d[95:80]);
    roll = vec_angle(gy, gz);
    sin_cos(roll, sr, cr);
    pitch = vec_angle(-gx * HALF_PI_A, gy * sr + gz * cr);
    if (pitch > HALF_PI_A) pitch = PI_A - pitch;
    else if (pitch < -HALF_PI_A) pitch = -PI_A - pitch;
    sin_cos(pitch, sp, cp);
    if (cp < 0) cp = -cp;
    num = mz * sr - my * cr;
    den = mx * cp + my * ((sp * sr) >>> 30) + mz * ((sp * cr) >>> 30);
    h = vec_angle(num, den);
    deg = ((h * 18000 + HALF_PI_A) >>> 31) - longint'(decl_copy);
    hd = deg[16:0];
  endtask

  // monitor: requests, results and config writes seen at the rising edge
  always @(posedge clk) begin
    logic signed [16:0] hd;
    in_acc  <= in_tvalid && in_tready;
    out_acc <= out_tvalid && out_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        decl_copy = cfg_data;
        cfg_writes <= cfg_writes + 1;
      end
      if (in_tvalid && in_tready) begin
        compass_heading(in_tdata, hd);
        heading_q.push_back(hd);
      end
      if (out_tvalid && out_tready) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, $signed(out_tdata[16:0]));
          n_errors++;
        end else begin
          hd = heading_q.pop_front();
          if (out_tdata[16:0] !== hd) begin
            $display("%0t: heading mismatch, expected %0d, actual %0d",
                     $time, hd, $signed(out_tdata[16:0]));
            n_errors++;
          end
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: timeout with %0d requests waiting, %0d results waiting",
               $time, sample_q.size(), heading_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    logic vld;
    vld = in_tvalid;
    if (rst_n && !(in_tvalid && !in_acc)) begin
      vld = 1'b0;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (sample_q.size() > 0) begin
        in_tdata <= sample_q.pop_front();
        vld = 1'b1;
        n_sent++;
        send_gap <= calm ? 0 : $urandom_range(0, 17);
      end
    end
    in_tvalid <= vld;
  end

  // receiver
  always @(negedge clk) begin
    int st;
    st = recv_stall;
    if (out_acc) st = calm ? 0 : $urandom_range(0, 17);
    else if (st > 0) st--;
    recv_stall <= st;
    out_tready <= rst_n && (st == 0);
  end

  task automatic add_sample(input logic signed [15:0] mx, my, mz, gx, gy, gz);
    sample_q.push_back({gz, gy, gx, mz, my, mx});
  endtask

  task automatic drain;
    wait (sample_q.size() == 0 && !in_tvalid && heading_q.size() == 0);
    repeat (5 * tcch_pkg::NSTG + 20) @(posedge clk);
  endtask

  task automatic set_declination(input logic signed [15:0] v);
    int n;
    drain();
    n = cfg_writes;
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    wait (cfg_writes != n);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_burst(input int count);
    int k;
    logic signed [15:0] g;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        // plausible tilted attitude, gravity dominated by one axis
        g = $urandom_range(0, 1) ? 16'sd981 : -16'sd981;
        add_sample(16'($urandom), 16'($urandom), 16'($urandom),
                   $signed(16'($urandom_range(0, 1200))) - 16'sd600,
                   $signed(16'($urandom_range(0, 1200))) - 16'sd600,
                   g + $signed(16'($urandom_range(0, 200))) - 16'sd100);
      end else if (k < 9) begin
        add_sample(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        add_sample($signed(16'($urandom_range(0, 3))) - 16'sd1,
                   $signed(16'($urandom_range(0, 3))) - 16'sd1,
                   $signed(16'($urandom_range(0, 3))) - 16'sd1,
                   $signed(16'($urandom_range(0, 3))) - 16'sd1,
                   $signed(16'($urandom_range(0, 3))) - 16'sd1,
                   $signed(16'($urandom_range(0, 3))) - 16'sd1);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: level, flipped, degenerate vectors, extremes, pitch at +/-90
    calm = 1'b1;
    add_sample(0, 0, 0, 0, 0, 0);
    add_sample(1000, 0, 0, 0, 0, 981);
    add_sample(0, 1000, 0, 0, 0, 981);
    add_sample(-1000, 0, 0, 0, 0, 981);
    add_sample(0, -1000, 0, 0, 0, 981);
    add_sample(-1000, -1, 0, 0, 0, 981);
    add_sample(1000, 500, 200, 0, 0, -981);
    add_sample(1000, 500, 200, 981, 0, 0);
    add_sample(1000, 500, 200, -981, 0, 0);
    add_sample(300, -400, 700, 0, 981, 0);
    add_sample(300, -400, 700, 0, -981, 0);
    add_sample(300, -400, 700, 0, 0, 0);
    add_sample(0, 0, 0, 200, 300, 900);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767);
    add_sample(32767, -32768, 32767, -32768, 32767, -32768);
    add_sample(-32768, 32767, -32768, 32767, -32768, 32767);
    add_sample(-32768, 0, 0, 0, 0, 1);
    add_sample(-32768, 0, 0, 0, 0, -1);
    add_sample(1, -1, 1, -32768, 1, -1);
    drain();
    calm = 1'b0;

    set_declination(16'sd18000);
    random_burst(100);
    set_declination(-16'sd18000);
    random_burst(100);
    set_declination($signed(16'($urandom_range(0, 36000))) - 16'sd18000);
    calm = 1'b1;
    random_burst(60);
    wait (sample_q.size() == 0);
    calm = 1'b0;
    random_burst(100);
    set_declination(16'sd0);
    random_burst(120);

    drain();
    $display("Covered %0d requests, %0d results checked, declination at both limits",
             n_sent, n_checked);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
